// ===== src/cpd_pkg.sv =====
package cpd_pkg;

  // frame delimiters and limits
  localparam logic [7:0]  START_BYTE     = 8'hA1;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [7:0]  TYPE_LIMIT     = 8'd200;
  localparam logic [7:0]  MAX_LEN_RESET  = 8'd200;

  // frame completion codes
  typedef enum logic [1:0] {
    FS_NONE     = 2'd0,
    FS_GOOD     = 2'd1,
    FS_MISMATCH = 2'd2,
    FS_REJECT   = 2'd3
  } frame_status_t;

  // one result item
  typedef struct packed {
    frame_status_t frame_status;
    logic          payload_valid;
    logic [7:0]    payload_index;
    logic [7:0]    payload_data;
    logic [7:0]    packet_type;
    logic [7:0]    packet_length;
  } result_t;

  // one byte of crc-16/mcrf4xx (reflected poly 0x8408)
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = b ^ crc[7:0];
    x = x ^ (x << 4);
    return {x, crc[15:8]} ^ {12'd0, x[7:4]} ^ {5'd0, x, 3'd0};
  endfunction

endpackage

// ===== src/cpd_core.sv =====
module cpd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr,
  input  logic [7:0]      cfg_data,
  input  logic            acc,
  input  logic [7:0]      in_byte,
  output cpd_pkg::result_t res
);
  import cpd_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT    = 3'd0,
    S_TYPE    = 3'd1,
    S_LEN     = 3'd2,
    S_CRCLO   = 3'd3,
    S_CRCHI   = 3'd4,
    S_PAYLOAD = 3'd5
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  max_len_r, max_len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] crc_upd;
  logic [7:0]  count_inc;

  assign crc_upd   = crc_step(crc_r, in_byte);
  assign count_inc = count_r + 8'd1;

  // frame parser next state and result
  always_comb begin
    state_nxt   = state_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    rx_crc_nxt  = rx_crc_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    max_len_nxt = cfg_wr ? cfg_data : max_len_r;
    res.frame_status  = FS_NONE;
    res.payload_valid = 1'b0;
    res.payload_index = 8'd0;
    res.payload_data  = 8'd0;
    unique case (state_r)
      S_TYPE: begin
        if (in_byte > TYPE_LIMIT) begin
          res.frame_status = FS_REJECT;
          state_nxt = S_HUNT;
        end else begin
          type_nxt  = in_byte;
          crc_nxt   = crc_step(CRC_INIT, in_byte);
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        len_nxt = in_byte;
        if (in_byte > max_len_r) begin
          res.frame_status = FS_REJECT;
          state_nxt = S_HUNT;
        end else begin
          crc_nxt   = crc_upd;
          state_nxt = S_CRCLO;
        end
      end
      S_CRCLO: begin
        rx_crc_nxt = {8'd0, in_byte};
        state_nxt  = S_CRCHI;
      end
      S_CRCHI: begin
        rx_crc_nxt = {in_byte, rx_crc_r[7:0]};
        count_nxt  = 8'd0;
        if (len_r == 8'd0) begin
          res.frame_status = (crc_r == {in_byte, rx_crc_r[7:0]}) ? FS_GOOD : FS_MISMATCH;
          state_nxt = S_HUNT;
        end else begin
          state_nxt = S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_index = count_r;
        res.payload_data  = in_byte;
        crc_nxt   = crc_upd;
        count_nxt = count_inc;
        if (count_inc == len_r) begin
          res.frame_status = (crc_upd == rx_crc_r) ? FS_GOOD : FS_MISMATCH;
          state_nxt = S_HUNT;
        end
      end
      default: begin
        state_nxt = (in_byte == START_BYTE) ? S_TYPE : S_HUNT;
      end
    endcase
    res.packet_type   = type_nxt;
    res.packet_length = len_nxt;
  end

  // state registers, updated per accepted byte, and config register, loaded on every cfg write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_HUNT;
      max_len_r <= MAX_LEN_RESET;
      type_r    <= 8'd0;
      len_r     <= 8'd0;
      rx_crc_r  <= 16'd0;
      crc_r     <= CRC_INIT;
      count_r   <= 8'd0;
    end else begin
      max_len_r <= max_len_nxt;
      if (acc) begin
        state_r  <= state_nxt;
        type_r   <= type_nxt;
        len_r    <= len_nxt;
        rx_crc_r <= rx_crc_nxt;
        crc_r    <= crc_nxt;
        count_r  <= count_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // start byte during hunt opens a frame
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && state_r == S_HUNT && in_byte == START_BYTE) |=> (state_r == S_TYPE))
    else $error("start byte did not open a frame");

  // any finished or rejected frame returns to the hunt
  a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.frame_status != FS_NONE) |=> (state_r == S_HUNT))
    else $error("parser did not return to hunt after frame end");

  // payload counter stays below the held length
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAYLOAD) |-> (count_r < len_r))
    else $error("payload count overran length");

  // payload bytes only come from the payload phase
  a_pvalid: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.payload_valid) |=> (state_r == S_PAYLOAD || state_r == S_HUNT))
    else $error("payload byte outside payload phase");
`endif

endmodule

// ===== src/cpd_out_stage.sv =====
module cpd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cpd_pkg::result_t res,
  output logic             can_load,
  output logic             out_tvalid,
  input  logic             out_tready,
  output cpd_pkg::result_t res_r
);
  import cpd_pkg::*;

  logic valid_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== src/crc16_packet_deframer_unit.sv =====
// output: a result is registered and shows on the out side in the cycle after its byte
// throughput: one byte per cycle while in_tready is high, one result per byte; output
//   register takes a new result whenever it is empty or being drained in the same cycle
// reset: rst_n synchronous active low; parser returns to hunt, crc to 0xFFFF,
//   max payload length to 200, output register empty
module crc16_packet_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // max_payload_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // payload_index, payload_data, packet_type, packet_length
  output logic [2:0]  out_tuser   // frame_status[1:0], payload_valid
);
  import cpd_pkg::*;

  result_t res;
  result_t res_r;
  logic    acc;

  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && in_tready;

  cpd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid),
    .cfg_data (cfg_data),
    .acc      (acc),
    .in_byte  (in_tdata),
    .res      (res)
  );

  cpd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (acc),
    .res        (res),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_r      (res_r)
  );

  // pack result fields
  assign out_tuser = {res_r.payload_valid, res_r.frame_status};
  assign out_tdata = {res_r.packet_length, res_r.packet_type,
                      res_r.payload_data, res_r.payload_index};

endmodule
